### hdl/vsd_pkg.sv
// voxel smoke dissolve: shared types, register indexes and widths
// used by every file of the block; depends on nothing

package vsd_pkg;

  // value format and configuration widths
  localparam int VALUE_BITS    = 24;
  localparam int FRAC_BITS     = 16;
  localparam int SPEED_BITS    = 16;
  localparam int CFG_IDX_BITS  = 4;
  localparam int CFG_DATA_BITS = 16;

  // accept edge to the edge that samples the result strobe
  localparam int LATENCY = VALUE_BITS + 3;

  // configuration register indexes
  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_SPEED,
    REG_EXP_MODE,
    REG_HEAT_EN,
    REG_COLOUR_EN
  } cfg_reg_t;

  typedef logic        [VALUE_BITS-1:0] val_t;
  typedef logic signed [VALUE_BITS-1:0] sval_t;

  // one voxel request
  typedef struct packed {
    val_t  density_in;
    sval_t heat_in;
    val_t  red_in;
    val_t  green_in;
    val_t  blue_in;
    logic  last_cell;
  } vsd_in_t;

  // one decayed voxel
  typedef struct packed {
    val_t  density_out;
    sval_t heat_out;
    val_t  red_out;
    val_t  green_out;
    val_t  blue_out;
    logic  last_out;
  } vsd_out_t;

endpackage

### hdl/vsd_div.sv
// pipelined multiply then restoring divide: q = floor(a * b / d)
// one quotient bit per stage; caller keeps b <= d so q fits W bits
// depends on vsd_pkg for the default width

module vsd_div #(
  parameter int W = vsd_pkg::VALUE_BITS
) (
  input  logic         clk,
  input  logic [W-1:0] a,
  input  logic [W-1:0] b,
  input  logic [W-1:0] d,
  output logic [W-1:0] q
);

  logic [2*W-1:0] prod_c;
  logic [2*W-1:0] prod_r;
  logic [W-1:0]   dsr_r;

  logic [W-1:0] rem_c [0:W];
  logic [W-1:0] lo_c  [0:W];
  logic [W-1:0] quo_c [0:W];
  logic [W-1:0] dvs_c [0:W];

  // product stage
  assign prod_c = {{W{1'b0}}, a} * {{W{1'b0}}, b};

  always_ff @(posedge clk) begin
    prod_r <= prod_c;
    dsr_r  <= d;
  end

  // upper half seeds the partial remainder, it is already below d
  assign rem_c[0] = prod_r[2*W-1:W];
  assign lo_c[0]  = prod_r[W-1:0];
  assign quo_c[0] = '0;
  assign dvs_c[0] = dsr_r;

  // one trial subtract per stage
  for (genvar k = 0; k < W; k++) begin : g_stage
    logic [W:0]   trial;
    logic [W:0]   diff;
    logic         take;
    logic [W-1:0] rem_r;
    logic [W-1:0] lo_r;
    logic [W-1:0] quo_r;
    logic [W-1:0] dvs_r;

    assign trial = {rem_c[k], lo_c[k][W-1]};
    assign diff  = trial - {1'b0, dvs_c[k]};
    assign take  = (trial >= {1'b0, dvs_c[k]});

    always_ff @(posedge clk) begin
      rem_r <= take ? diff[W-1:0] : trial[W-1:0];
      lo_r  <= {lo_c[k][W-2:0], 1'b0};
      quo_r <= {quo_c[k][W-2:0], take};
      dvs_r <= dvs_c[k];
    end

    assign rem_c[k+1] = rem_r;
    assign lo_c[k+1]  = lo_r;
    assign quo_c[k+1] = quo_r;
    assign dvs_c[k+1] = dvs_r;
  end

  assign q = quo_c[W];

endmodule

### hdl/voxel_smoke_dissolve_top.sv
// voxel smoke dissolve top level: config registers, step unit, lanes
// depends on vsd_pkg and vsd_div
//
// path: stage a, the product stage, the VALUE_BITS divide stages and the output register lead to the result strobe
// throughput: one voxel per cycle while busy is low; each lane holds a pipelined multiply and VALUE_BITS-stage divide
// a dissolve_speed write holds busy high while the bit-serial step divide runs
// reset: synchronous active low; clears valid bits, speed to 1, mode flags to 0
// the receiver cannot stall, results appear as a single-cycle strobe

module voxel_smoke_dissolve_top #(
  parameter int FRAC_BITS = vsd_pkg::FRAC_BITS
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  vsd_pkg::vsd_in_t                    in_req,
  output logic                                out_vld,
  output vsd_pkg::vsd_out_t                   out_rsp,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [vsd_pkg::CFG_IDX_BITS-1:0]    cfg_index,
  input  logic [vsd_pkg::CFG_DATA_BITS-1:0]   cfg_data
);

  localparam int VB        = vsd_pkg::VALUE_BITS;
  localparam int SB        = vsd_pkg::SPEED_BITS;
  localparam int STEP_BITS = FRAC_BITS + 1;
  localparam int CW        = ((VB > FRAC_BITS) ? VB : FRAC_BITS) + 1;
  localparam int CNT_BITS  = $clog2(STEP_BITS);
  localparam int DEPTH     = VB + 1;
  localparam int LANES     = 5;

  localparam logic [CNT_BITS-1:0]  CNT_TOP  = CNT_BITS'(FRAC_BITS);
  localparam logic [STEP_BITS-1:0] STEP_ONE = {1'b1, {FRAC_BITS{1'b0}}};

  typedef enum logic {ST_IDLE, ST_CALC} calc_state_t;

  // side data that travels beside the divider lanes
  typedef struct packed {
    logic          last;
    logic [VB-1:0] heat_in;
    logic          heat_neg;
    logic [VB-1:0] heat_lin;
    logic [VB-1:0] nd_lin;
    logic [VB-1:0] red_in;
    logic [VB-1:0] green_in;
    logic [VB-1:0] blue_in;
    logic          dens_zero;
  } side_t;

  // configuration and step unit
  calc_state_t          state_r;
  logic                 busy_r;
  logic [SB-1:0]        spd_r;
  logic                 exp_r;
  logic                 heat_en_r;
  logic                 col_en_r;
  logic [STEP_BITS-1:0] step_r;
  logic [CNT_BITS-1:0]  cnt_r;
  logic [SB-1:0]        srem_r;
  logic [FRAC_BITS-1:0] squo_r;
  logic [SB:0]          strial;
  logic [SB:0]          sdiff;
  logic                 stake;
  logic                 cfg_wr;

  assign cfg_ready = !busy_r;
  assign busy      = busy_r;
  assign cfg_wr    = cfg_valid && cfg_ready;

  // the dividend is one followed by FRAC_BITS zeros
  assign strial = {srem_r, (cnt_r == CNT_TOP)};
  assign sdiff  = strial - {1'b0, spd_r};
  assign stake  = (strial >= {1'b0, spd_r});

  // register writes and the bit-serial step divide
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      busy_r    <= 1'b0;
      spd_r     <= SB'(1);
      exp_r     <= 1'b0;
      heat_en_r <= 1'b0;
      col_en_r  <= 1'b0;
      step_r    <= STEP_ONE;
      cnt_r     <= '0;
      srem_r    <= '0;
      squo_r    <= '0;
    end else begin
      case (state_r)
        ST_IDLE: begin
          if (cfg_wr) begin
            case (cfg_index)
              vsd_pkg::REG_SPEED: begin
                // a speed of zero behaves as one
                spd_r   <= (cfg_data[SB-1:0] == '0) ? SB'(1) : cfg_data[SB-1:0];
                state_r <= ST_CALC;
                busy_r  <= 1'b1;
                cnt_r   <= CNT_TOP;
                srem_r  <= '0;
                squo_r  <= '0;
              end
              vsd_pkg::REG_EXP_MODE:  exp_r     <= cfg_data[0];
              vsd_pkg::REG_HEAT_EN:   heat_en_r <= cfg_data[0];
              vsd_pkg::REG_COLOUR_EN: col_en_r  <= cfg_data[0];
              default: ;
            endcase
          end
        end
        ST_CALC: begin
          srem_r <= stake ? sdiff[SB-1:0] : strial[SB-1:0];
          squo_r <= {squo_r[FRAC_BITS-2:0], stake};
          cnt_r  <= cnt_r - CNT_BITS'(1);
          if (cnt_r == '0) begin
            state_r <= ST_IDLE;
            busy_r  <= 1'b0;
            step_r  <= {squo_r, stake};
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  // stage a: capture the request, heat magnitude, linear density
  logic             acc;
  logic             a_vld_r;
  vsd_pkg::vsd_in_t a_in_r;
  logic             a_neg_r;
  logic [VB-1:0]    a_mag_r;
  logic [VB-1:0]    a_nd_r;
  logic [VB-1:0]    heat_u;
  logic [VB-1:0]    mag_nxt;
  logic [CW-1:0]    step_x;
  logic [CW-1:0]    dens_x;
  logic [CW-1:0]    nd_diff;
  logic [VB-1:0]    nd_nxt;

  assign acc     = start && !busy_r;
  assign heat_u  = in_req.heat_in;
  assign mag_nxt = heat_u[VB-1] ? (~heat_u + VB'(1)) : heat_u;
  assign step_x  = CW'(step_r);
  assign dens_x  = CW'(in_req.density_in);
  assign nd_diff = dens_x - step_x;
  assign nd_nxt  = (dens_x > step_x) ? nd_diff[VB-1:0] : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
    end else begin
      a_vld_r <= acc;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      a_in_r  <= in_req;
      a_neg_r <= heat_u[VB-1];
      a_mag_r <= mag_nxt;
      a_nd_r  <= nd_nxt;
    end
  end

  // linear heat: toward zero by the step, zero once below it
  logic [CW-1:0] mag_x;
  logic [CW-1:0] mdiff;
  logic [VB-1:0] hmag;
  logic [VB-1:0] heat_lin;

  assign mag_x    = CW'(a_mag_r);
  assign mdiff    = mag_x - step_x;
  assign hmag     = mdiff[VB-1:0];
  assign heat_lin = (mag_x < step_x) ? '0 : (a_neg_r ? (~hmag + VB'(1)) : hmag);

  // divider lanes: density, heat magnitude, red, green, blue
  logic [VB-1:0] spd_x;
  logic [VB-1:0] spd_m1;
  logic [VB-1:0] lane_b;
  logic [VB-1:0] lane_d;
  logic [VB-1:0] lane_a [0:LANES-1];
  logic [VB-1:0] lane_q [0:LANES-1];

  assign spd_x  = {{(VB-SB){1'b0}}, spd_r};
  assign spd_m1 = spd_x - VB'(1);
  // exponential: x * (s - 1) / s; linear colour: c * new / old
  assign lane_b = exp_r ? spd_m1 : a_nd_r;
  assign lane_d = exp_r ? spd_x  : a_in_r.density_in;

  assign lane_a[0] = a_in_r.density_in;
  assign lane_a[1] = a_mag_r;
  assign lane_a[2] = a_in_r.red_in;
  assign lane_a[3] = a_in_r.green_in;
  assign lane_a[4] = a_in_r.blue_in;

  for (genvar l = 0; l < LANES; l++) begin : g_lane
    vsd_div #(
      .W (VB)
    ) u_div (
      .clk (clk),
      .a   (lane_a[l]),
      .b   (lane_b),
      .d   (lane_d),
      .q   (lane_q[l])
    );
  end

  // side line, as deep as the lanes
  side_t            side_nxt;
  side_t            side_r [0:DEPTH-1];
  logic [DEPTH-1:0] vld_r;

  always_comb begin
    side_nxt.last      = a_in_r.last_cell;
    side_nxt.heat_in   = a_in_r.heat_in;
    side_nxt.heat_neg  = a_neg_r;
    side_nxt.heat_lin  = heat_lin;
    side_nxt.nd_lin    = a_nd_r;
    side_nxt.red_in    = a_in_r.red_in;
    side_nxt.green_in  = a_in_r.green_in;
    side_nxt.blue_in   = a_in_r.blue_in;
    side_nxt.dens_zero = (a_in_r.density_in == '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[DEPTH-2:0], a_vld_r};
    end
  end

  always_ff @(posedge clk) begin
    side_r[0] <= side_nxt;
    for (int k = 1; k < DEPTH; k++) begin
      side_r[k] <= side_r[k-1];
    end
  end

  // output stage: pick decayed or passed values
  side_t             sd;
  logic [VB-1:0]     qh;
  logic              col_dec;
  vsd_pkg::vsd_out_t out_nxt;
  vsd_pkg::vsd_out_t out_rsp_r;
  logic              out_vld_r;

  assign sd      = side_r[DEPTH-1];
  assign qh      = sd.heat_neg ? (~lane_q[1] + VB'(1)) : lane_q[1];
  assign col_dec = col_en_r && (exp_r || !sd.dens_zero);

  always_comb begin
    out_nxt.density_out = exp_r ? lane_q[0] : sd.nd_lin;
    if (!heat_en_r) begin
      out_nxt.heat_out = sd.heat_in;
    end else begin
      out_nxt.heat_out = exp_r ? qh : sd.heat_lin;
    end
    out_nxt.red_out   = col_dec ? lane_q[2] : sd.red_in;
    out_nxt.green_out = col_dec ? lane_q[3] : sd.green_in;
    out_nxt.blue_out  = col_dec ? lane_q[4] : sd.blue_in;
    out_nxt.last_out  = sd.last;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= vld_r[DEPTH-1];
    end
  end

  always_ff @(posedge clk) begin
    out_rsp_r <= out_nxt;
  end

  assign out_vld = out_vld_r;
  assign out_rsp = out_rsp_r;

endmodule

### hdl/vsd_check.sv
// port-level checks for the voxel smoke dissolve top level, with its bind
// depends on vsd_pkg and voxel_smoke_dissolve_top

module vsd_check #(
  parameter int LATENCY = vsd_pkg::LATENCY
) (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              start,
  input logic                              busy,
  input vsd_pkg::vsd_in_t                  in_req,
  input logic                              out_vld,
  input vsd_pkg::vsd_out_t                 out_rsp,
  input logic                              cfg_valid,
  input logic                              cfg_ready,
  input logic [vsd_pkg::CFG_IDX_BITS-1:0]  cfg_index
);

  // every accepted request gives a result after the fixed latency
  a_req_to_rsp: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##LATENCY out_vld)
    else $error("request gave no result");

  // no result without a request the latency earlier
  a_rsp_from_req: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld |-> $past(start && !busy, LATENCY))
    else $error("result without request");

  // the grid end marker stays with its voxel
  a_last_align: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld |-> (out_rsp.last_out == $past(in_req.last_cell, LATENCY)))
    else $error("last marker out of step");

  // a speed write starts the step divide and closes the config port
  a_speed_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (cfg_valid && cfg_ready && (cfg_index == vsd_pkg::REG_SPEED)) |=> (busy && !cfg_ready))
    else $error("speed write did not raise busy");

endmodule

bind voxel_smoke_dissolve_top vsd_check #(
  .LATENCY (vsd_pkg::LATENCY)
) u_vsd_check (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .in_req    (in_req),
  .out_vld   (out_vld),
  .out_rsp   (out_rsp),
  .cfg_valid (cfg_valid),
  .cfg_ready (cfg_ready),
  .cfg_index (cfg_index)
);
